@@ src/qnmr_pkg.sv @@
// Shared types and constants for the quantized neuron MAC/requantize block.
// Used by qnmr_alu, qnmr_ctrl and quantized_neuron_mac_requant; no dependencies.
package qnmr_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned ElemW = 8;
  localparam int unsigned AddrW = 4;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] RegZeroPoint = 2'd0;
  localparam logic [1:0] RegScale     = 2'd1;
  localparam logic [1:0] RegShift     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_BIAS,
    ST_SCALE,
    ST_SHIFT
  } qnmr_state_e;

  typedef enum logic {
    ALU_MULADD,
    ALU_ASR
  } qnmr_op_e;

  typedef enum logic [1:0] {
    SRC_MAC,
    SRC_BIAS,
    SRC_SCALE,
    SRC_SHIFT
  } qnmr_src_e;

  typedef struct packed {
    logic      in_ready;
    qnmr_op_e  op;
    qnmr_src_e src;
    logic      acc_we;
    logic      acc_clr;
    logic      work_we;
    logic      out_we;
  } qnmr_ctrl_t;

endpackage

@@ src/qnmr_alu.sv @@
// Shared arithmetic unit: 32-bit wrapping multiply-add or arithmetic right shift.
// Depends on qnmr_pkg.
module qnmr_alu (
  input  qnmr_pkg::qnmr_op_e                  op_i,
  input  logic [qnmr_pkg::DataW-1:0]          a_i,
  input  logic [qnmr_pkg::DataW-1:0]          b_i,
  input  logic [qnmr_pkg::DataW-1:0]          c_i,
  input  logic [qnmr_pkg::ShiftW-1:0]         shamt_i,
  output logic [qnmr_pkg::DataW-1:0]          y_o
);
  import qnmr_pkg::*;

  logic [DataW-1:0] prod;
  logic [DataW-1:0] shifted;

  // Low word of the product is the same for signed and unsigned operands
  assign prod    = a_i * b_i;
  assign shifted = DataW'($signed(a_i) >>> shamt_i);

  // Select the operation result
  always_comb begin
    unique case (op_i)
      ALU_MULADD: y_o = prod + c_i;
      ALU_ASR:    y_o = shifted;
      default:    y_o = prod + c_i;
    endcase
  end

endmodule

@@ src/qnmr_ctrl.sv @@
// Sequencer that steps the shared ALU through MAC, bias, scale and shift.
// Depends on qnmr_pkg.
module qnmr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  last_i,
  input  logic                  out_busy_i,
  output qnmr_pkg::qnmr_state_e state_o,
  output qnmr_pkg::qnmr_ctrl_t  ctrl_o
);
  import qnmr_pkg::*;

  qnmr_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and step controls
  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    ctrl_o.op       = ALU_MULADD;
    ctrl_o.src      = SRC_MAC;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) state_d = ST_MAC;
      end
      ST_MAC: begin
        ctrl_o.acc_we = 1'b1;
        state_d = last_i ? ST_BIAS : ST_IDLE;
      end
      ST_BIAS: begin
        ctrl_o.src     = SRC_BIAS;
        ctrl_o.work_we = 1'b1;
        ctrl_o.acc_clr = 1'b1;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        ctrl_o.src     = SRC_SCALE;
        ctrl_o.work_we = 1'b1;
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        ctrl_o.src = SRC_SHIFT;
        ctrl_o.op  = ALU_ASR;
        // Hold until the output register is free
        if (!out_busy_i) begin
          ctrl_o.out_we = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule

@@ src/quantized_neuron_mac_requant.sv @@
// Quantized neuron MAC with requantize: one shared multiply-add/shift unit under a sequencer.
// Steps: accept, MAC for a non-last transaction; accept, MAC, bias add, scale multiply,
// shift for a last one, all on the single shared ALU. No new transaction is accepted
// until the steps are done; the shift step holds while the output register is full.
// Reset (rst_ni, async active low): accumulator 0, zero point 0, scale 1, shift 0, no output.
// Depends on qnmr_pkg, qnmr_alu and qnmr_ctrl.
module quantized_neuron_mac_requant (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [qnmr_pkg::ElemW-1:0]       activation_i,
  input  logic [qnmr_pkg::ElemW-1:0]       weight_i,
  input  logic signed [qnmr_pkg::DataW-1:0] bias_i,
  input  logic                             last_item_i,
  // Output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [qnmr_pkg::DataW-1:0] neuron_value_o,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qnmr_pkg::AddrW-1:0]       paddr,
  input  logic [qnmr_pkg::DataW-1:0]       pwdata,
  output logic [qnmr_pkg::DataW-1:0]       prdata,
  output logic                             pready
);
  import qnmr_pkg::*;

  qnmr_state_e state;
  qnmr_ctrl_t  ctrl;

  logic [ElemW-1:0]  zp_q;
  logic [DataW-1:0]  scale_q;
  logic [ShiftW-1:0] shift_q;

  logic [ElemW-1:0]  act_q;
  logic [ElemW:0]    diff_q;
  logic [DataW-1:0]  bias_q;
  logic              last_q;
  logic [DataW-1:0]  acc_q;
  logic [DataW-1:0]  work_q;
  logic [DataW-1:0]  out_q;
  logic              out_valid_q;

  logic [DataW-1:0]  alu_a, alu_b, alu_c, alu_y;
  logic              in_fire;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zp_q    <= '0;
      scale_q <= DataW'(1);
      shift_q <= '0;
    end else if (cfg_wr) begin
      if (cfg_idx == RegZeroPoint) zp_q    <= pwdata[ElemW-1:0];
      if (cfg_idx == RegScale)     scale_q <= pwdata;
      if (cfg_idx == RegShift)     shift_q <= pwdata[ShiftW-1:0];
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    if (cfg_idx == RegZeroPoint) prdata = DataW'(zp_q);
    if (cfg_idx == RegScale)     prdata = scale_q;
    if (cfg_idx == RegShift)     prdata = DataW'(shift_q);
  end

  qnmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_q),
    .out_busy_i (out_valid_q && !out_ready_i),
    .state_o    (state),
    .ctrl_o     (ctrl)
  );

  assign in_ready_o = ctrl.in_ready;
  assign in_fire    = in_valid_i && ctrl.in_ready;

  // Capture the transaction; weight minus zero point fits in 9 signed bits
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= activation_i;
      diff_q <= {1'b0, weight_i} - {1'b0, zp_q};
      bias_q <= bias_i;
      last_q <= last_item_i;
    end
  end

  // Route operands to the shared unit for the current step
  always_comb begin
    unique case (ctrl.src)
      SRC_MAC: begin
        alu_a = DataW'(act_q);
        alu_b = {{(DataW-ElemW-1){diff_q[ElemW]}}, diff_q};
        alu_c = acc_q;
      end
      SRC_BIAS: begin
        alu_a = acc_q;
        alu_b = DataW'(1);
        alu_c = bias_q;
      end
      SRC_SCALE: begin
        alu_a = work_q;
        alu_b = scale_q;
        alu_c = '0;
      end
      SRC_SHIFT: begin
        alu_a = work_q;
        alu_b = '0;
        alu_c = '0;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
        alu_c = '0;
      end
    endcase
  end

  qnmr_alu u_alu (
    .op_i    (ctrl.op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .c_i     (alu_c),
    .shamt_i (shift_q),
    .y_o     (alu_y)
  );

  // Accumulator: add each product, clear once the bias step has read it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl.acc_we) begin
      acc_q <= alu_y;
    end
  end

  // Working value for the requantize steps
  always_ff @(posedge clk_i) begin
    if (ctrl.work_we) work_q <= alu_y;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_we) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_we) out_q <= alu_y;
  end

  assign out_valid_o    = out_valid_q;
  assign neuron_value_o = out_q;

  // A result appears only at the end of the shift step
  a_out_from_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state == ST_SHIFT))
    else $error("result produced outside the shift step");

  // The accumulator is empty once a result has been loaded
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_we |=> (acc_q == '0))
    else $error("accumulator not cleared after result");

  // A last transaction always walks MAC, bias, scale in consecutive cycles
  a_seq_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_MAC && last_q) |=> (state == ST_BIAS) ##1 (state == ST_SCALE))
    else $error("requantize sequence out of order");

endmodule
